>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sensor batch statistics block.
// Each macro expands to one labeled concurrent assertion on clk / arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SBS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define SBS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/sbs_pkg.sv
// Package of the sensor batch statistics block: widths, register indexes,
// the divider request type. Used by sbs_div and sensor_batch_statistics.
`timescale 1ns / 1ps
`default_nettype none
package sbs_pkg;
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_BATCH_SIZE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_TEMP_LIMIT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PRESS_LIMIT = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_VIB_LIMIT = 2'd3;
	localparam int unsigned CfgW = 15;

	localparam int unsigned DivW = 64;   // dividend magnitude width
	localparam int unsigned DvsW = 33;   // divisor width

	// one accumulator entry: count, temp sum, pressure max, vibration sum, energy sum
	typedef struct packed {
		logic [7:0]         cnt;
		logic signed [23:0] tsum;
		logic [13:0]        pmax;
		logic [18:0]        vsum;
		logic signed [39:0] esum;
	} acc_t;
	localparam int unsigned AccW = $bits(acc_t);

	typedef struct packed {
		logic                   start;
		logic signed [DivW-1:0] num;
		logic [DvsW-1:0]        den;
	} div_req_t;
endpackage
`default_nettype wire

>>> hw/rtl/sbs_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sbs_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]              rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/sbs_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sbs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sbs_div import sbs_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire div_req_t       req,
	output logic                busy,
	output logic                done,
	output logic signed [DivW-1:0] quo
);
	localparam int unsigned CntW = $clog2(DivW + 1);
	logic [DivW-1:0] q_q;
	logic [DvsW:0]   r_q;
	logic [DvsW-1:0] d_q;
	logic            neg_q;
	logic [CntW-1:0] cnt_q;
	logic [DvsW:0]   trial;
	logic [DvsW:0]   diff;

	assign trial = {r_q[DvsW-1:0], q_q[DivW-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy  <= 1'b1;
				cnt_q <= CntW'(DivW);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.num[DivW-1] ? DivW'(-req.num) : req.num;
			neg_q <= req.num[DivW-1];
			r_q   <= '0;
			d_q   <= req.den;
		end else if (busy) begin
			if (!diff[DvsW]) begin
				r_q <= diff;
				q_q <= {q_q[DivW-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[DivW-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);

	`SBS_ASSERT_NEXT(a_done_ends_busy, done, !busy)
	`SBS_ASSERT_IMP(a_no_start_busy, req.start, !busy)
endmodule
`default_nettype wire

>>> hw/rtl/sensor_batch_statistics.sv
// Sensor batch statistics block: input channel (sensor reading), output
// channel (event / summary items), plain configuration write port.
// Depends on sbs_pkg, sbs_ram, sbs_div, assert_macros.svh.
//
// Use: a reading is taken with in_valid high and in_stall low. The block then
// reads the sensor's accumulators from a RAM with registered read data, divides
// T*P by V+10 on the shared serial divider, updates and writes back the
// entry. A reading over any limit gives an event item; a reading that closes
// a batch gives a summary item, which takes two more divider runs (averages)
// and one more for the running average temperature. The last item of a
// reading has last = 1; an event precedes a summary.
// One reading is in work at a time: input stall is high until the block has
// written back its entry, handed off its items and returned to idle.
// Reset clears all control and global state and the accumulator valid bits
// (16 entries); registers return to their reset values. When the receiver
// stalls, the output item holds and the block waits.
// Out-of-range sensor ids (>= SENSORS) are dropped without effect.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sensor_batch_statistics import sbs_pkg::*; #(
	parameter int unsigned SENSORS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgW-1:0]     cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [3:0]          sensor,
	input  wire logic signed [14:0]  temp_in,
	input  wire logic [13:0]         pressure_in,
	input  wire logic [10:0]         vibration_in,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     kind,
	output logic                     last,
	output logic [3:0]               sensor_out,
	output logic [7:0]               readings,
	output logic signed [14:0]       temperature,
	output logic [13:0]              pressure,
	output logic [18:0]              vibration,
	output logic signed [30:0]       energy_term,
	output logic signed [14:0]       cum_avg_temperature,
	output logic [13:0]              cum_max_pressure,
	output logic [47:0]              cum_total_vibration,
	output logic [31:0]              cum_readings
);
	localparam int unsigned AddrW = (SENSORS > 1) ? $clog2(SENSORS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_TERM, ST_TWAIT, ST_UPD, ST_EVT, ST_AVGT, ST_AVGE,
		ST_RUN, ST_SUM, ST_OUT
	} state_t;
	state_t state_q;

	// configuration
	logic [7:0]         bsize_q;
	logic signed [14:0] tlim_q;
	logic [13:0]        plim_q;
	logic [10:0]        vlim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= 8'd16;
			tlim_q  <= 15'sd8500;
			plim_q  <= 14'd5000;
			vlim_q  <= 11'd400;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BATCH_SIZE: bsize_q <= cfg_data[7:0];
				REG_TEMP_LIMIT: tlim_q  <= $signed(cfg_data[14:0]);
				REG_PRESS_LIMIT: plim_q <= cfg_data[13:0];
				REG_VIB_LIMIT:  vlim_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// accumulator RAM, valid bits for reset-to-zero
	logic [SENSORS-1:0] vld_q;
	logic               ram_we;
	acc_t               ram_wd, ram_rd, acc_q;
	logic [AddrW-1:0]   addr_q;

	sbs_ram #(.Width(AccW), .Depth(SENSORS)) u_acc_ram (
		.clk(clk), .we(ram_we), .waddr(addr_q), .wdata(ram_wd),
		.raddr(addr_q), .rdata(ram_rd)
	);

	// divider
	div_req_t              dreq;
	logic                  dbusy, ddone;
	logic signed [DivW-1:0] dquo;
	sbs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy),
		.done(ddone), .quo(dquo));

	// reading and work registers
	logic signed [14:0] t_q;
	logic [13:0]        p_q;
	logic [10:0]        v_q;
	logic signed [29:0] tp_q;
	logic signed [30:0] term_q;
	logic               crit_q, close_q;
	logic signed [14:0] avgt_q;
	logic signed [30:0] avge_q;

	// global state
	logic [31:0]        nb_q;
	logic signed [15:0] run_q;
	logic [13:0]        omax_q;
	logic [47:0]        ovib_q;
	logic [31:0]        ordg_q;

	// updated entry (combinational from acc_q)
	acc_t               nxt;
	logic [8:0]         cnt_w;
	logic signed [24:0] ts_w;
	logic [19:0]        vs_w;
	logic signed [40:0] es_w;
	logic [31:0]        nb_w;
	logic [48:0]        ov_w;
	logic [32:0]        or_w;

	always_comb begin
		cnt_w = {1'b0, acc_q.cnt} + 9'd1;
		ts_w  = 25'(acc_q.tsum) + 25'(t_q);
		vs_w  = {1'b0, acc_q.vsum} + 20'(v_q);
		es_w  = 41'(acc_q.esum) + 41'(term_q);
		nxt.cnt  = cnt_w[8] ? 8'hFF : cnt_w[7:0];
		nxt.tsum = (ts_w > 25'sd8388607) ? 24'sd8388607 :
			(ts_w < -25'sd8388608) ? -24'sd8388608 : ts_w[23:0];
		nxt.pmax = (p_q > acc_q.pmax) ? p_q : acc_q.pmax;
		nxt.vsum = vs_w[19] ? 19'h7FFFF : vs_w[18:0];
		nxt.esum = (es_w > 41'sd549755813887) ? 40'sd549755813887 :
			(es_w < -41'sd549755813888) ? -40'sd549755813888 : es_w[39:0];
		nb_w = (nb_q == 32'hFFFF_FFFF) ? nb_q : nb_q + 32'd1;
		ov_w = {1'b0, ovib_q} + 49'(acc_q.vsum);
		or_w = {1'b0, ordg_q} + 33'(acc_q.cnt);
	end

	logic signed [DivW-1:0] run_num;
	always_comb run_num = 64'(run_q) * $signed({1'b0, nb_q - 32'd1}) + 64'(avgt_q);

	always_comb begin
		dreq = '0;
		ram_we = 1'b0;
		ram_wd = nxt;
		case (state_q)
			ST_TERM: begin
				dreq.start = 1'b1;
				dreq.num = 64'(tp_q);
				dreq.den = 33'(v_q) + 33'd10;
			end
			ST_UPD: begin
				ram_we = 1'b1;
				if (nxt.cnt >= bsize_q) ram_wd = '0;
			end
			ST_AVGT: if (!dbusy && !ddone) begin
				dreq.start = 1'b1;
				dreq.num = 64'(acc_q.tsum);
				dreq.den = 33'(acc_q.cnt);
			end
			ST_AVGE: if (!dbusy && !ddone) begin
				dreq.start = 1'b1;
				dreq.num = 64'(acc_q.esum);
				dreq.den = 33'(acc_q.cnt);
			end
			ST_RUN: if (!dbusy && !ddone) begin
				dreq.start = 1'b1;
				dreq.num = run_num;
				dreq.den = {1'b0, nb_q};
			end
			default: ;
		endcase
	end

	logic started_q;
	logic in_acc;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vld_q     <= '0;
			out_valid <= 1'b0;
			nb_q      <= '0;
			run_q     <= '0;
			omax_q    <= '0;
			ovib_q    <= '0;
			ordg_q    <= '0;
			started_q <= 1'b0;
			acc_q     <= '0;
			term_q    <= '0;
			close_q   <= 1'b0;
			avgt_q    <= '0;
			avge_q    <= '0;
			kind      <= 1'b0;
			last      <= 1'b0;
			sensor_out <= '0;
			readings  <= '0;
			temperature <= '0;
			pressure  <= '0;
			vibration <= '0;
			energy_term <= '0;
			cum_avg_temperature <= '0;
			cum_max_pressure <= '0;
			cum_total_vibration <= '0;
			cum_readings <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc && (32'(sensor) < SENSORS)) state_q <= ST_RD;
				ST_RD: state_q <= ST_TERM;
				ST_TERM: begin
					acc_q <= vld_q[addr_q] ? ram_rd : '0;
					state_q <= ST_TWAIT;
				end
				ST_TWAIT: if (ddone) begin
					term_q  <= dquo[30:0];
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					vld_q[addr_q] <= 1'b1;
					acc_q   <= nxt;
					close_q <= (nxt.cnt >= bsize_q);
					if (crit_q) begin
						kind <= 1'b0;
						last <= !(nxt.cnt >= bsize_q);
						sensor_out <= 4'(addr_q);
						readings <= '0;
						temperature <= t_q;
						pressure <= p_q;
						vibration <= 19'(v_q);
						energy_term <= term_q;
						cum_avg_temperature <= run_q[14:0];
						cum_max_pressure <= omax_q;
						cum_total_vibration <= ovib_q;
						cum_readings <= ordg_q;
						out_valid <= 1'b1;
						state_q <= ST_EVT;
					end else if (nxt.cnt >= bsize_q) state_q <= ST_AVGT;
					else state_q <= ST_IDLE;
				end
				ST_EVT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= close_q ? ST_AVGT : ST_IDLE;
				end
				ST_AVGT: begin
					if (!dbusy && !ddone) started_q <= 1'b1;
					if (ddone && started_q) begin
						avgt_q <= dquo[14:0];
						started_q <= 1'b0;
						state_q <= ST_AVGE;
					end
				end
				ST_AVGE: begin
					if (!dbusy && !ddone) started_q <= 1'b1;
					if (ddone && started_q) begin
						avge_q <= dquo[30:0];
						started_q <= 1'b0;
						nb_q <= nb_w;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!dbusy && !ddone) started_q <= 1'b1;
					if (ddone && started_q) begin
						run_q <= dquo[15:0];
						started_q <= 1'b0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (acc_q.pmax > omax_q) omax_q <= acc_q.pmax;
					ovib_q <= ov_w[48] ? 48'hFFFF_FFFF_FFFF : ov_w[47:0];
					ordg_q <= or_w[32] ? 32'hFFFF_FFFF : or_w[31:0];
					state_q <= ST_OUT;
					kind <= 1'b1;
					last <= 1'b1;
					sensor_out <= 4'(addr_q);
					readings <= acc_q.cnt;
					temperature <= avgt_q;
					pressure <= acc_q.pmax;
					vibration <= acc_q.vsum;
					energy_term <= avge_q;
					cum_avg_temperature <= run_q[14:0];
					cum_max_pressure <= (acc_q.pmax > omax_q) ? acc_q.pmax : omax_q;
					cum_total_vibration <= ov_w[48] ? 48'hFFFF_FFFF_FFFF : ov_w[47:0];
					cum_readings <= or_w[32] ? 32'hFFFF_FFFF : or_w[31:0];
					out_valid <= 1'b1;
				end
				ST_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// reading capture and product (one multiplier, registered)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= AddrW'(sensor);
			t_q <= temp_in;
			p_q <= pressure_in;
			v_q <= vibration_in;
		end
		if (state_q == ST_RD) begin
			tp_q <= 30'(t_q) * $signed({16'd0, p_q});
			crit_q <= (t_q > tlim_q) || (p_q > plim_q) || (v_q > vlim_q);
		end
	end

	`SBS_ASSERT_IMP(a_out_only_when_busy, out_valid, state_q != ST_IDLE)
	`SBS_ASSERT_IMP(a_wb_not_idle, ram_we, !in_stall == 1'b0)
	`SBS_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid && $stable(energy_term))
endmodule
`default_nettype wire

>>> tb/sv/sensor_batch_statistics_tb.sv
// Self-checking bench for sensor_batch_statistics: drives readings and config
// writes, predicts event and summary items in a scoreboard class.
// Depends on sbs_pkg and the block's RTL.
`timescale 1ns / 1ps
module sensor_batch_statistics_tb;
	import sbs_pkg::*;

	// one expected output item, at the port widths
	typedef struct {
		bit               kind;
		bit               last;
		bit [3:0]         sensor;
		bit [7:0]         readings;
		bit [14:0]        temperature;
		bit [13:0]        pressure;
		bit [18:0]        vibration;
		bit [30:0]        energy;
		bit [14:0]        cum_temp;
		bit [13:0]        cum_press;
		bit [47:0]        cum_vib;
		bit [31:0]        cum_readings;
	} stat_item_t;

	// Batch statistics predictor plus the queue of items still owed by the block.
	class batch_scoreboard;
		// limits and batch size as last written
		longint batch_len, t_limit, p_limit, v_limit;
		// per-sensor accumulators
		longint cnt[16], tsum[16], pmax[16], vsum[16], esum[16];
		// totals over all closed batches
		longint closed, avg_temp, max_press, tot_vib, tot_readings;
		stat_item_t owed[$];
		int errors;

		function new();
			batch_len = 16; t_limit = 8500; p_limit = 5000; v_limit = 400;
			foreach (cnt[i]) begin
				cnt[i] = 0; tsum[i] = 0; pmax[i] = 0; vsum[i] = 0; esum[i] = 0;
			end
			closed = 0; avg_temp = 0; max_press = 0; tot_vib = 0; tot_readings = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
			case (idx)
				REG_BATCH_SIZE: batch_len = val[7:0];
				REG_TEMP_LIMIT: t_limit = longint'($signed(val[14:0]));
				REG_PRESS_LIMIT: p_limit = val[13:0];
				default: v_limit = val[10:0];
			endcase
		endfunction

		function stat_item_t make(bit k, longint s, longint n, longint t, longint p,
				longint v, longint e);
			stat_item_t r;
			r.kind = k; r.last = 0; r.sensor = 4'(s); r.readings = 8'(n);
			r.temperature = 15'(t); r.pressure = 14'(p); r.vibration = 19'(v);
			r.energy = 31'(e);
			r.cum_temp = 15'(avg_temp); r.cum_press = 14'(max_press);
			r.cum_vib = 48'(tot_vib); r.cum_readings = 32'(tot_readings);
			return r;
		endfunction

		// accepted reading: update accumulators, queue what it should cause
		function void note_reading(logic [3:0] s, logic signed [14:0] t_raw,
				logic [13:0] p_raw, logic [10:0] v_raw);
			longint t, p, v, term, avg_t, avg_e;
			int made;
			t = t_raw; p = p_raw; v = v_raw;
			made = 0;
			term = (t * p) / (v + 10);
			if (t > t_limit || p > p_limit || v > v_limit) begin
				owed.insert(owed.size(), make(0, s, 0, t, p, v, term));
				made++;
			end
			cnt[s] = (cnt[s] >= 255) ? 255 : cnt[s] + 1;
			tsum[s] += t;
			if (tsum[s] > 8388607) tsum[s] = 8388607;
			if (tsum[s] < -8388608) tsum[s] = -8388608;
			if (p > pmax[s]) pmax[s] = p;
			vsum[s] += v;
			if (vsum[s] > 'h7FFFF) vsum[s] = 'h7FFFF;
			esum[s] += term;
			if (esum[s] > 64'sd549755813887) esum[s] = 64'sd549755813887;
			if (esum[s] < -64'sd549755813888) esum[s] = -64'sd549755813888;
			if (cnt[s] >= batch_len) begin
				avg_t = tsum[s] / cnt[s];
				avg_e = esum[s] / cnt[s];
				if (closed < 64'sd4294967295) closed++;
				avg_temp = (avg_temp * (closed - 1) + avg_t) / closed;
				if (pmax[s] > max_press) max_press = pmax[s];
				tot_vib += vsum[s];
				if (tot_vib > 64'sh0000_FFFF_FFFF_FFFF) tot_vib = 64'sh0000_FFFF_FFFF_FFFF;
				tot_readings += cnt[s];
				if (tot_readings > 64'sd4294967295) tot_readings = 64'sd4294967295;
				owed.insert(owed.size(), make(1, s, cnt[s], avg_t, pmax[s], vsum[s], avg_e));
				made++;
				cnt[s] = 0; tsum[s] = 0; pmax[s] = 0; vsum[s] = 0; esum[s] = 0;
			end
			if (made > 0) owed[$].last = 1;
		endfunction

		task report(string msg);
			$display("%0t ns MISMATCH: %s", $realtime, msg);
			errors++;
		endtask

		task cmp(string name, bit [63:0] got, bit [63:0] want);
			if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
		endtask

		task check_item(stat_item_t got);
			stat_item_t w;
			if (owed.size() == 0) begin
				report("output item with nothing expected");
				return;
			end
			w = owed.pop_front();
			cmp("kind", got.kind, w.kind);
			cmp("last", got.last, w.last);
			cmp("sensor_out", got.sensor, w.sensor);
			cmp("readings", got.readings, w.readings);
			cmp("temperature", got.temperature, w.temperature);
			cmp("pressure", got.pressure, w.pressure);
			cmp("vibration", got.vibration, w.vibration);
			cmp("energy_term", got.energy, w.energy);
			cmp("cum_avg_temperature", got.cum_temp, w.cum_temp);
			cmp("cum_max_pressure", got.cum_press, w.cum_press);
			cmp("cum_total_vibration", got.cum_vib, w.cum_vib);
			cmp("cum_readings", got.cum_readings, w.cum_readings);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [3:0] sensor = '0;
	logic signed [14:0] temp_in = '0;
	logic [13:0] pressure_in = '0;
	logic [10:0] vibration_in = '0;
	logic out_valid;
	logic out_stall = 0;
	logic kind, last;
	logic [3:0] sensor_out;
	logic [7:0] readings;
	logic signed [14:0] temperature;
	logic [13:0] pressure;
	logic [18:0] vibration;
	logic signed [30:0] energy_term;
	logic signed [14:0] cum_avg_temperature;
	logic [13:0] cum_max_pressure;
	logic [47:0] cum_total_vibration;
	logic [31:0] cum_readings;

	batch_scoreboard sb = new();
	bit quiet = 0;        // no idling on either side in the closing phase
	bit hold_req = 0;     // asks the receiver for one long hold-off
	int hold_left = 0;
	int burst_left = 0;

	sensor_batch_statistics dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Receiver: random stall bursts, plus one long hold-off on request. The
	// long hold lets the block fill up with a pending item and stall its input.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			out_stall = 1;
			hold_left--;
		end else if (quiet) begin
			out_stall = 0;
		end else if (burst_left > 0) begin
			out_stall = 1;
			burst_left--;
		end else begin
			out_stall = 0;
			if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(1, 9);
		end
	end

	// Output monitor: an item moves when valid is high and stall is low.
	always @(posedge clk) begin
		stat_item_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = kind; got.last = last; got.sensor = sensor_out;
			got.readings = readings; got.temperature = temperature;
			got.pressure = pressure; got.vibration = vibration;
			got.energy = energy_term; got.cum_temp = cum_avg_temperature;
			got.cum_press = cum_max_pressure; got.cum_vib = cum_total_vibration;
			got.cum_readings = cum_readings;
			sb.check_item(got);
		end
	end

	// Offer one reading and hold it until taken; valid stays high for a
	// back-to-back follower, otherwise this task itself drops it for a random gap.
	task automatic send_reading(logic [3:0] s, logic [14:0] t, logic [13:0] p,
			logic [10:0] v);
		@(negedge clk);
		sensor = s; temp_in = t; pressure_in = p; vibration_in = v;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		sb.note_reading(s, t, p, v);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
		end
	endtask

	// Drain, then let any reading that makes no item finish before writing.
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [7:0] len, logic [14:0] tl, logic [13:0] pl,
			logic [10:0] vl);
		drain();
		@(negedge clk);
		cfg_we = 1; cfg_index = REG_BATCH_SIZE; cfg_data = CfgW'(len);
		sb.set_reg(REG_BATCH_SIZE, CfgW'(len));
		@(negedge clk);
		cfg_index = REG_TEMP_LIMIT; cfg_data = tl;
		sb.set_reg(REG_TEMP_LIMIT, tl);
		@(negedge clk);
		cfg_index = REG_PRESS_LIMIT; cfg_data = CfgW'(pl);
		sb.set_reg(REG_PRESS_LIMIT, CfgW'(pl));
		@(negedge clk);
		cfg_index = REG_VIB_LIMIT; cfg_data = CfgW'(vl);
		sb.set_reg(REG_VIB_LIMIT, CfgW'(vl));
		@(negedge clk);
		cfg_we = 0;
	endtask

	// Random reading: mostly a few busy sensors with values in range so that
	// batches close often; now and then raw bit patterns.
	task automatic send_random(int busy);
		logic [3:0] s;
		logic [14:0] t;
		logic [13:0] p;
		logic [10:0] v;
		s = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, busy)) :
			4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) == 0) begin
			t = 15'($urandom); p = 14'($urandom); v = 11'($urandom);
		end else begin
			t = 15'($urandom_range(0, 19000) - 4000);
			p = 14'($urandom_range(0, 10000));
			v = 11'($urandom_range(0, 2000));
		end
		send_reading(s, t, p, v);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes and limit boundaries at reset settings
		send_reading(15, 15'h4000, 0, 0);
		send_reading(0, 15'h3FFF, 14'h3FFF, 11'h7FF);
		send_reading(1, 8500, 5000, 400);
		send_reading(1, 8501, 5000, 400);
		send_reading(1, 8500, 5001, 400);
		send_reading(1, 8500, 5000, 401);
		send_reading(2, -4000, 0, 0);
		send_reading(2, 15000, 10000, 2000);
		send_reading(2, -4000, 10000, 0);
		for (int i = 0; i < 15; i++) send_reading(3, 15'(1000 + i), 4000, 100);
		// sixteenth reading closes the batch and is critical: event, then summary
		send_reading(3, 9000, 4000, 100);

		for (int i = 0; i < 250; i++) begin
			if (i == 100) hold_req = 1;
			send_random(3);
		end
		// sender pauses until every item has come back
		drain();

		// batch size one; every reading closes a batch
		write_cfg(1, 15000, 10000, 2000);
		for (int i = 0; i < 250; i++) send_random(15);

		// largest batch, lowest limits: nearly every reading critical
		write_cfg(255, -4000, 0, 0);
		for (int i = 0; i < 420; i++) send_random(0);

		// batch size zero closes on every reading
		write_cfg(0, 15'h4000, 14'h3FFF, 11'h7FF);
		for (int i = 0; i < 200; i++) send_random(7);

		write_cfg(4, 8000, 6000, 1000);
		for (int i = 0; i < 400; i++) send_random(5);

		write_cfg(8, 3000, 2000, 100);
		quiet = 1;
		for (int i = 0; i < 400; i++) send_random(3);

		drain();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
